[rtl/rmst_pkg.sv]
// Package for the range maximum segment tree.
// Holds the request and response payload types, the controller to datapath
// command and status structs, and the default size constants. No dependencies.
`timescale 1ns / 1ps

package rmst_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int IDX_W      = 10;
    localparam int HALF_W     = 16;
    localparam int PAIR_W     = 2 * HALF_W;

    typedef struct packed {
        logic              mode;
        logic [IDX_W-1:0]  first_index;
        logic [IDX_W-1:0]  last_index;
        logic [HALF_W-1:0] new_key;
        logic [HALF_W-1:0] new_tag;
    } t_req;

    typedef struct packed {
        logic [HALF_W-1:0] best_key;
        logic [HALF_W-1:0] best_tag;
    } t_rsp;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // latch a request and set up the walk
        logic clr;      // write zero at the clear pointer and advance it
        logic u_leaf;   // write the leaf, read its sibling
        logic u_rd;     // read the sibling of the current node
        logic u_wr;     // write the parent as the larger child, move up
        logic q_rd_a;   // read the left boundary node, step it right
        logic q_rd_b;   // read the right boundary node, step it left
        logic q_acc;    // fold the read data into the running maximum
        logic q_shift;  // move both boundaries up one level
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic upd_ok;   // incoming update index lies inside the tree
        logic a_gt_b;   // query boundaries have crossed
        logic a_odd;
        logic b_even;
        logic at_top;   // parent of the current node is the root
        logic clr_last; // clear pointer is at the last entry
    } t_sts;

endpackage

[rtl/rmst_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rmst_datapath.sv]
// Datapath of the range maximum segment tree: node pointers, running maximum,
// clear pointer and the tree memory. Depends on rmst_pkg and rmst_ram.
`timescale 1ns / 1ps

module rmst_datapath #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rmst_pkg::t_req i_req,
    input  rmst_pkg::t_cmd i_cmd,
    output rmst_pkg::t_sts o_sts,
    output rmst_pkg::t_rsp o_rsp
);

    localparam int LW = $clog2(LEAVES);
    localparam int AW = LW + 1;   // memory address: 2*LEAVES entries
    localparam int NW = LW + 2;   // node pointer: must hold 2*LEAVES
    localparam int PW = rmst_pkg::PAIR_W;

    function automatic logic [PW-1:0] pair_max(input logic [PW-1:0] x,
                                               input logic [PW-1:0] y);
        return (x > y) ? x : y;
    endfunction

    logic [NW-1:0] r_a, n_a;
    logic [NW-1:0] r_b, n_b;
    logic [PW-1:0] r_cur, n_cur;
    logic [PW-1:0] r_best, n_best;
    logic [AW-1:0] r_clr;

    logic          first_ok;
    logic          last_ok;
    logic [NW-1:0] lo_node;
    logic [NW-1:0] hi_node;
    logic [NW-1:0] parent;
    logic [PW-1:0] up_val;

    logic          we;
    logic [AW-1:0] waddr;
    logic [PW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [PW-1:0] rdata;

    assign first_ok = 32'(i_req.first_index) < 32'(LEAVES);
    assign last_ok  = 32'(i_req.last_index) < 32'(LEAVES);

    // A lower bound beyond the leaves starts past every upper bound, so the
    // walk ends at once with an empty result.
    assign lo_node = first_ok ? (NW'(LEAVES) + NW'(i_req.first_index))
                              : NW'(2 * LEAVES);
    assign hi_node = NW'(LEAVES) + (last_ok ? NW'(i_req.last_index)
                                            : NW'(LEAVES - 1));

    assign parent = r_a >> 1;
    assign up_val = pair_max(r_cur, rdata);

    always_comb begin
        n_a    = r_a;
        n_b    = r_b;
        n_cur  = r_cur;
        n_best = r_best;
        if (i_cmd.load) begin
            n_a    = lo_node;
            n_b    = hi_node;
            n_cur  = {i_req.new_key, i_req.new_tag};
            n_best = '0;
        end
        if (i_cmd.u_wr) begin
            n_a   = parent;
            n_cur = up_val;
        end
        if (i_cmd.q_acc) begin
            n_best = pair_max(r_best, rdata);
        end
        if (i_cmd.q_rd_a) begin
            n_a = r_a + NW'(1);
        end
        if (i_cmd.q_rd_b) begin
            n_b = r_b - NW'(1);
        end
        if (i_cmd.q_shift) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_cur  <= n_cur;
        r_best <= n_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    assign we = i_cmd.clr | i_cmd.u_leaf | i_cmd.u_wr;

    always_comb begin
        if (i_cmd.clr) begin
            waddr = r_clr;
            wdata = '0;
        end else if (i_cmd.u_leaf) begin
            waddr = r_a[AW-1:0];
            wdata = r_cur;
        end else begin
            waddr = parent[AW-1:0];
            wdata = up_val;
        end
    end

    always_comb begin
        if (i_cmd.q_rd_a) begin
            raddr = r_a[AW-1:0];
        end else if (i_cmd.q_rd_b) begin
            raddr = r_b[AW-1:0];
        end else begin
            raddr = r_a[AW-1:0] ^ AW'(1);
        end
    end

    rmst_ram #(
        .WIDTH (PW),
        .DEPTH (2 * LEAVES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign o_sts.upd_ok   = first_ok;
    assign o_sts.a_gt_b   = r_a > r_b;
    assign o_sts.a_odd    = r_a[0];
    assign o_sts.b_even   = ~r_b[0];
    assign o_sts.at_top   = (parent == NW'(1));
    assign o_sts.clr_last = &r_clr;

    assign o_rsp.best_key = r_best[PW-1:rmst_pkg::HALF_W];
    assign o_rsp.best_tag = r_best[rmst_pkg::HALF_W-1:0];

endmodule

[rtl/rmst_ctrl.sv]
// Controller of the range maximum segment tree: sequences the clear pass,
// the leaf-to-root update walk and the boundary walk of a query.
// Depends on rmst_pkg.
`timescale 1ns / 1ps

module rmst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_mode,
    input  rmst_pkg::t_sts i_sts,
    output rmst_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_ULEAF = 4'd2;
    localparam logic [3:0] S_URD   = 4'd3;
    localparam logic [3:0] S_UWR   = 4'd4;
    localparam logic [3:0] S_QTOP  = 4'd5;
    localparam logic [3:0] S_QA    = 4'd6;
    localparam logic [3:0] S_QB    = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_mode == rmst_pkg::MODE_QUERY) begin
                        n_state = S_QTOP;
                    end else if (i_sts.upd_ok) begin
                        n_state = S_ULEAF;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ULEAF: begin
                o_cmd.u_leaf = 1'b1;
                n_state      = S_UWR;
            end
            S_URD: begin
                o_cmd.u_rd = 1'b1;
                n_state    = S_UWR;
            end
            S_UWR: begin
                o_cmd.u_wr = 1'b1;
                n_state    = i_sts.at_top ? S_DONE : S_URD;
            end
            S_QTOP: begin
                if (i_sts.a_gt_b) begin
                    n_state = S_DONE;
                end else if (i_sts.a_odd) begin
                    o_cmd.q_rd_a = 1'b1;
                    n_state      = S_QA;
                end else if (i_sts.b_even) begin
                    o_cmd.q_rd_b = 1'b1;
                    n_state      = S_QB;
                end else begin
                    o_cmd.q_shift = 1'b1;
                end
            end
            S_QA: begin
                // The right boundary is tested against its value before the
                // left boundary stepped, as in one level of the walk.
                o_cmd.q_acc = 1'b1;
                if (i_sts.b_even) begin
                    o_cmd.q_rd_b = 1'b1;
                    n_state      = S_QB;
                end else begin
                    o_cmd.q_shift = 1'b1;
                    n_state       = S_QTOP;
                end
            end
            S_QB: begin
                o_cmd.q_acc   = 1'b1;
                o_cmd.q_shift = 1'b1;
                n_state       = S_QTOP;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted without going busy");

    a_step_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.q_rd_a, o_cmd.q_rd_b, o_cmd.q_shift}))
        else $error("conflicting boundary steps in one cycle");

    a_write_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.clr, o_cmd.u_leaf, o_cmd.u_wr}))
        else $error("two memory writes requested in one cycle");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr |-> (!o_done && !o_cmd.load))
        else $error("request handled during the clear pass");
`endif

endmodule

[rtl/range_max_segment_tree.sv]
// Top level of the range maximum segment tree: controller plus datapath.
// Depends on rmst_pkg, rmst_ctrl, rmst_datapath (and through it rmst_ram).
`timescale 1ns / 1ps

// A request is taken when i_start is high while o_busy is low, and every
// request gives exactly one response on o_rsp, marked by o_done for a single
// cycle; the receiver cannot stall, so it must take the response in that
// cycle. After reset the block runs a clear pass over all 2*LEAVES entries,
// one tree entry per cycle, with o_busy high. The tree memory has one write
// and one read port with registered read, and that port sets the order of
// the steps: an update writes the leaf, then does one sibling read and one
// parent write per level; a query does up to two node reads and a shift per
// level of the boundary walk. An update returns zeros; a query with an
// empty range returns zeros.
module range_max_segment_tree #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  rmst_pkg::t_req i_req,
    output logic           o_busy,
    output logic           o_done,
    output rmst_pkg::t_rsp o_rsp
);

    rmst_pkg::t_cmd cmd;
    rmst_pkg::t_sts sts;

    rmst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_mode  (i_req.mode),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    rmst_datapath #(
        .LEAVES (LEAVES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

[test/testbench.sv]
// Self-checking testbench for range_max_segment_tree: directed table, then random requests.
// A shadow segment tree predicts each response that the directed table does not give. Depends on rmst_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int LEAVES       = rmst_pkg::LEAVES_DEF;
    localparam int IDX_W        = rmst_pkg::IDX_W;
    localparam int HALF_W       = rmst_pkg::HALF_W;
    localparam int PAIR_W       = rmst_pkg::PAIR_W;
    localparam int RANDOM_REQS  = 450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOT_SPAN     = 64;
    localparam int DIRECTED_MAX = 32;
    localparam int AWAIT_DEPTH  = 16;

    typedef struct {
        rmst_pkg::t_req req;
        bit             typed;
        rmst_pkg::t_rsp rsp;
    } t_row;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    rmst_pkg::t_req i_req   = '0;
    logic           o_busy;
    logic           o_done;
    rmst_pkg::t_rsp o_rsp;

    logic [PAIR_W-1:0] pair_shadow [0:2*LEAVES-1];
    rmst_pkg::t_rsp    awaited_max [0:AWAIT_DEPTH-1];
    int                await_wr = 0;
    int                await_rd = 0;
    t_row              directed_rows [0:DIRECTED_MAX-1];
    int                row_count = 0;
    int                mismatch_count = 0;
    int                cycle_count = 0;

    range_max_segment_tree #(.LEAVES(LEAVES)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_req  (i_req),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_rsp  (o_rsp)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic rmst_pkg::t_req make_req(input logic mode,
                                                input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi,
                                                input logic [HALF_W-1:0] key,
                                                input logic [HALF_W-1:0] tag);
        rmst_pkg::t_req r;
        r.mode        = mode;
        r.first_index = lo;
        r.last_index  = hi;
        r.new_key     = key;
        r.new_tag     = tag;
        return r;
    endfunction

    function automatic void shadow_leaf_write(input int leaf, input logic [PAIR_W-1:0] val);
        int k;
        k = leaf + LEAVES;
        pair_shadow[k] = val;
        for (k = k >> 1; k >= 1; k = k >> 1) begin
            pair_shadow[k] = (pair_shadow[2*k] > pair_shadow[2*k+1]) ?
                             pair_shadow[2*k] : pair_shadow[2*k+1];
        end
    endfunction

    function automatic logic [PAIR_W-1:0] shadow_range_max(input int lo, input int hi);
        logic [PAIR_W-1:0] best;
        int a;
        int b;
        best = '0;
        if (hi >= LEAVES) hi = LEAVES - 1;
        if (lo > hi) return '0;
        a = lo + LEAVES;
        b = hi + LEAVES;
        while (a <= b) begin
            if (a % 2 == 1) begin
                if (pair_shadow[a] > best) best = pair_shadow[a];
                a++;
            end
            if (b % 2 == 0) begin
                if (pair_shadow[b] > best) best = pair_shadow[b];
                b--;
            end
            a = a >> 1;
            b = b >> 1;
        end
        return best;
    endfunction

    // Applies one request to the shadow tree and returns the response it should give.
    function automatic rmst_pkg::t_rsp tree_step(input rmst_pkg::t_req r);
        logic [PAIR_W-1:0] best;
        best = '0;
        if (r.mode == rmst_pkg::MODE_UPDATE) begin
            if (int'(r.first_index) < LEAVES)
                shadow_leaf_write(int'(r.first_index), {r.new_key, r.new_tag});
        end else begin
            best = shadow_range_max(int'(r.first_index), int'(r.last_index));
        end
        return rmst_pkg::t_rsp'(best);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (roll < 55) return 0;
        if (roll < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    function automatic rmst_pkg::t_req random_req();
        int lo;
        int hi;
        int pick;
        logic [HALF_W-1:0] key;
        logic [HALF_W-1:0] tag;
        lo   = int'($urandom_range(0, LEAVES - 1));
        hi   = int'($urandom_range(0, LEAVES - 1));
        key  = HALF_W'($urandom_range(0, 65535));
        tag  = HALF_W'($urandom_range(0, 65535));
        pick = int'($urandom_range(0, 9));
        if ($urandom_range(0, 99) < 45) begin
            if (pick < 5) lo = int'($urandom_range(0, HOT_SPAN - 1));
            // Few distinct keys force the tag to break ties.
            if ($urandom_range(0, 9) < 3) key = HALF_W'($urandom_range(0, 3));
            return make_req(rmst_pkg::MODE_UPDATE, IDX_W'(lo), IDX_W'(hi), key, tag);
        end
        case (pick)
            4, 5: begin
                hi = lo + int'($urandom_range(0, 15));
                if (hi > LEAVES - 1) hi = LEAVES - 1;
            end
            6: hi = lo;
            7: begin
                lo = int'($urandom_range(0, 3));
                hi = LEAVES - 1 - int'($urandom_range(0, 3));
            end
            8, 9: begin
                lo = int'($urandom_range(0, HOT_SPAN - 1));
                hi = int'($urandom_range(lo, HOT_SPAN - 1));
            end
            default: ;
        endcase
        return make_req(rmst_pkg::MODE_QUERY, IDX_W'(lo), IDX_W'(hi), key, tag);
    endfunction

    task automatic add_row(input rmst_pkg::t_req r, input bit typed,
                           input logic [HALF_W-1:0] key, input logic [HALF_W-1:0] tag);
        t_row row;
        row.req   = r;
        row.typed = typed;
        row.rsp   = {key, tag};
        directed_rows[row_count] = row;
        row_count++;
    endtask

    // Holds the request until it is taken, then records the response it must give.
    task automatic issue_request(input rmst_pkg::t_req r, input bit typed,
                                 input rmst_pkg::t_rsp typed_rsp, input bit no_idle);
        rmst_pkg::t_rsp want;
        int             gap;
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        want = tree_step(r);
        if (typed) want = typed_rsp;
        awaited_max[await_wr % AWAIT_DEPTH] = want;
        await_wr++;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            i_req   <= random_req();
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_responses();
        i_start <= 1'b0;
        while (await_wr != await_rd) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        rmst_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (await_wr == await_rd) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected response: expected none, got key=%h tag=%h",
                             o_rsp.best_key, o_rsp.best_tag);
            end else begin
                want = awaited_max[await_rd % AWAIT_DEPTH];
                await_rd++;
                if (o_rsp.best_key !== want.best_key || o_rsp.best_tag !== want.best_tag) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected key=%h tag=%h, got key=%h tag=%h",
                                 want.best_key, want.best_tag, o_rsp.best_key,
                                 o_rsp.best_tag);
                end
            end
        end
    end

    initial begin
        for (int n = 0; n < 2 * LEAVES; n++) pair_shadow[n] = '0;

        add_row(make_req(rmst_pkg::MODE_QUERY, 0, 1023, 0, 0), 1, 16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 1023, 1023, 0, 0), 1, 16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 0, 0, 16'hFFFF, 16'hFFFF), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 1023, 1023, 16'h0001, 16'h0000), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 0, 1023, 0, 0), 1, 16'hFFFF, 16'hFFFF);
        add_row(make_req(rmst_pkg::MODE_QUERY, 1, 1023, 0, 0), 1, 16'h0001, 16'h0000);
        // Empty ranges, the lower bound above the upper one.
        add_row(make_req(rmst_pkg::MODE_QUERY, 1023, 0, 16'hFFFF, 16'hFFFF), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 5, 4, 0, 0), 1, 16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 512, 1023, 16'h1234, 16'hFFFF), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 513, 0, 16'h1234, 16'h0001), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 510, 515, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 512, 512, 16'h0000, 16'h0000), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 511, 513, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 0, 1023, 16'h0000, 16'h0000), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 0, 0, 0, 0), 1, 16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 0, 1023, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 1022, 5, 16'hFFFF, 16'h0000), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 1022, 1023, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_UPDATE, 700, 0, 16'h8000, 16'h7FFF), 1,
                16'h0000, 16'h0000);
        add_row(make_req(rmst_pkg::MODE_QUERY, 700, 700, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_QUERY, 1, 1022, 0, 0), 0, '0, '0);
        add_row(make_req(rmst_pkg::MODE_QUERY, 0, 1023, 0, 0), 0, '0, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < row_count; n++)
            issue_request(directed_rows[n].req, directed_rows[n].typed,
                          directed_rows[n].rsp, n < 6);
        wait_all_responses();

        for (int n = 0; n < RANDOM_REQS; n++) begin
            // One stretch in four runs back to back without idle cycles.
            issue_request(random_req(), 0, '0, ((n / 32) % 4) == 1);
            if (n % 100 == 99) wait_all_responses();
        end

        wait_all_responses();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
